// File: design/dlp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal line parser package
// Widths, character codes, result status codes and register map shared by
// the channel interfaces and the parser.
// ----------------------------------------------------------------------------
package dlp_pkg;

	// Payload widths.
	localparam int CHAR_W   = 8;
	localparam int VALUE_W  = 31;
	localparam int STATUS_W = 2;

	// Character codes.
	localparam logic [CHAR_W-1:0] BLANK_MAX = 8'd32;
	localparam logic [CHAR_W-1:0] DIGIT_LO  = 8'd48;
	localparam logic [CHAR_W-1:0] DIGIT_HI  = 8'd57;
	localparam logic [CHAR_W-1:0] NEWLINE   = 8'd10;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_PARSE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_READ  = 2'd2;

	// Register map: one 32-bit register, word index taken from paddr[2].
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_MAX_RESULT = 1'b0;

	localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

endpackage

// File: design/dlp_char_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character channel
// Carries one character byte or an end-of-file event per word.
// ----------------------------------------------------------------------------
interface dlp_char_if;
	logic                      valid;
	logic                      ready;
	logic [dlp_pkg::CHAR_W-1:0] char_byte;
	logic                      end_of_file;

	modport source (output valid, output char_byte, output end_of_file, input ready);
	modport sink (input valid, input char_byte, input end_of_file, output ready);
endinterface

// File: design/dlp_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Carries one parsed value with its status per word.
// ----------------------------------------------------------------------------
interface dlp_result_if;
	logic                        valid;
	logic                        ready;
	logic [dlp_pkg::VALUE_W-1:0]  parsed_value;
	logic [dlp_pkg::STATUS_W-1:0] status;

	modport source (output valid, output parsed_value, output status, input ready);
	modport sink (input valid, input parsed_value, input status, output ready);
endinterface

// File: design/decimal_line_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal line parser
// Parses lines of ASCII decimal digits into values with a range check.
// ----------------------------------------------------------------------------
// The parser takes one character word per clock cycle and gives one result
// word per newline or end-of-file event. A word accepted from the channel
// lands in the input register; the line state and, for a newline or
// end-of-file word, the result register are updated from it as it moves on.
// The line state loop (a multiply by ten built from two shifts and an add)
// is combinational, so the input stays ready every cycle except when a
// newline or end-of-file word waits in the input register while the result
// register is still held by the consumer. A line is optional blanks or
// control bytes, digits, then optional blanks; a line with no digits, a stray
// byte, a value above max_result or more than LINE_CAPACITY bytes gives a
// parse error (status 1), and end of file gives a read error (status 2).
// ----------------------------------------------------------------------------
module decimal_line_parser #(
	parameter int LINE_CAPACITY = 10
) (
	input  logic                         clk,
	input  logic                         arst_n,
	dlp_char_if.sink                     char_in,
	dlp_result_if.source                 result_out,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [dlp_pkg::PADDR_W-1:0]  paddr,
	input  logic [dlp_pkg::PDATA_W-1:0]  pwdata,
	output logic [dlp_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);

	localparam int CNT_W = $clog2(LINE_CAPACITY + 1);
	localparam int PROD_W = dlp_pkg::VALUE_W + 4;
	localparam logic [CNT_W-1:0] CAP = CNT_W'(LINE_CAPACITY);

	typedef enum logic [1:0] {PH_LEAD, PH_DIGITS, PH_TRAIL, PH_BAD} phase_t;

	// Configuration register.
	logic [dlp_pkg::VALUE_W-1:0] max_result_q;

	// Input register.
	logic                       valid_s1;
	logic [dlp_pkg::CHAR_W-1:0] char_s1;
	logic                       eof_s1;

	// Line state.
	phase_t                      phase_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [dlp_pkg::VALUE_W-1:0] acc_q;
	logic                        over_q;

	// Result register.
	logic                         out_valid_q;
	logic [dlp_pkg::VALUE_W-1:0]  value_q;
	logic [dlp_pkg::STATUS_W-1:0] status_q;

	// Next line state and result of the word in the input register.
	phase_t                       phase_d;
	logic [CNT_W-1:0]             cnt_d;
	logic [dlp_pkg::VALUE_W-1:0]  acc_d;
	logic                         over_d;
	logic                         res_c;
	logic [dlp_pkg::VALUE_W-1:0]  res_value_c;
	logic [dlp_pkg::STATUS_W-1:0] res_status_c;
	logic                         is_blank;
	logic                         is_digit;
	logic [PROD_W-1:0]            prod;
	logic                         fire;
	logic                         out_free;
	logic                         cfg_wr;

	// APB register access.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == dlp_pkg::REG_MAX_RESULT)
		? {{(dlp_pkg::PDATA_W - dlp_pkg::VALUE_W){1'b0}}, max_result_q}
		: '0;

	// Character classes and the digit accumulate step.
	assign is_blank = (char_s1 <= dlp_pkg::BLANK_MAX);
	assign is_digit = (char_s1 >= dlp_pkg::DIGIT_LO) && (char_s1 <= dlp_pkg::DIGIT_HI);
	assign prod = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1)
		+ PROD_W'(char_s1 - dlp_pkg::DIGIT_LO);

	// Handshake: a word without a result always moves on.
	assign out_free = !out_valid_q || result_out.ready;
	assign fire = valid_s1 && (!res_c || out_free);
	assign char_in.ready = !valid_s1 || fire;

	assign result_out.valid        = out_valid_q;
	assign result_out.parsed_value = value_q;
	assign result_out.status       = status_q;

	// Line state update for one word.
	always_comb begin
		phase_d      = phase_q;
		cnt_d        = cnt_q;
		acc_d        = acc_q;
		over_d       = over_q;
		res_c        = 1'b0;
		res_value_c  = '0;
		res_status_c = dlp_pkg::ST_PARSE;
		if (eof_s1 || (char_s1 == dlp_pkg::NEWLINE)) begin
			res_c = 1'b1;
			if (eof_s1) begin
				res_status_c = dlp_pkg::ST_READ;
			end else if ((phase_q == PH_DIGITS || phase_q == PH_TRAIL) && !over_q
					&& (acc_q <= max_result_q)) begin
				res_status_c = dlp_pkg::ST_OK;
				res_value_c  = acc_q;
			end
			phase_d = PH_LEAD;
			cnt_d   = '0;
			acc_d   = '0;
			over_d  = 1'b0;
		end else if (cnt_q >= CAP) begin
			phase_d = PH_BAD;
		end else begin
			cnt_d = cnt_q + 1'b1;
			case (phase_q)
				PH_LEAD, PH_DIGITS: begin
					if (is_digit) begin
						phase_d = PH_DIGITS;
						if (prod[PROD_W-1:dlp_pkg::VALUE_W] != '0) begin
							over_d = 1'b1;
							acc_d  = dlp_pkg::VALUE_MAX;
						end else begin
							acc_d = prod[dlp_pkg::VALUE_W-1:0];
						end
					end else if (!is_blank) begin
						phase_d = PH_BAD;
					end else if (phase_q == PH_DIGITS) begin
						phase_d = PH_TRAIL;
					end
				end
				PH_TRAIL: begin
					if (!is_blank) begin
						phase_d = PH_BAD;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// All registers: configuration, input stage, line state and result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_result_q <= dlp_pkg::VALUE_MAX;
			valid_s1     <= 1'b0;
			char_s1      <= '0;
			eof_s1       <= 1'b0;
			phase_q      <= PH_LEAD;
			cnt_q        <= '0;
			acc_q        <= '0;
			over_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			value_q      <= '0;
			status_q     <= dlp_pkg::ST_OK;
		end else begin
			if (cfg_wr && (paddr[2] == dlp_pkg::REG_MAX_RESULT)) begin
				max_result_q <= pwdata[dlp_pkg::VALUE_W-1:0];
			end
			if (char_in.ready) begin
				valid_s1 <= char_in.valid;
				char_s1  <= char_in.char_byte;
				eof_s1   <= char_in.end_of_file;
			end
			if (fire) begin
				phase_q <= phase_d;
				cnt_q   <= cnt_d;
				acc_q   <= acc_d;
				over_q  <= over_d;
			end
			if (fire && res_c) begin
				out_valid_q <= 1'b1;
				value_q     <= res_value_c;
				status_q    <= res_status_c;
			end else if (result_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The byte count never passes the line capacity.
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CAP)
		else $error("byte count above line capacity");

	// Leading blanks phase holds no value and no overflow.
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_LEAD |-> (acc_q == '0) && !over_q)
		else $error("value held during leading blanks");

	// A result clears the line state.
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && res_c |=> (cnt_q == '0) && (phase_q == PH_LEAD) && out_valid_q)
		else $error("line state not cleared after result");

	// A failed line carries a zero value.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q != dlp_pkg::ST_OK) |-> value_q == '0)
		else $error("nonzero value with error status");

endmodule

// File: dv/decimal_line_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal line parser testbench
// Streams character words into the parser and checks every result word
// against a line-by-line parsing model kept in the bench. Directed lines cover
// the value extremes, stray bytes, overlong lines and end of file. Random
// lines then run under several max_result settings, with bursty input and a
// stalling result consumer.
// ----------------------------------------------------------------------------
module decimal_line_parser_test;

	localparam int LINE_CAPACITY = 10;
	localparam int STALL_LIMIT   = 2000;
	localparam int DRAIN_LIMIT   = 500;
	localparam int SETTLE_CYCLES = 4;
	localparam logic [dlp_pkg::PADDR_W-1:0] MAX_RESULT_ADDR = {dlp_pkg::REG_MAX_RESULT, 2'b00};

	typedef enum logic [1:0] {LINE_LEAD, LINE_DIGITS, LINE_TRAIL, LINE_BAD} line_phase_t;

	typedef struct packed {
		logic [dlp_pkg::VALUE_W-1:0]  value;
		logic [dlp_pkg::STATUS_W-1:0] status;
	} line_result_t;

	logic                        clk;
	logic                        arst_n;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [dlp_pkg::PADDR_W-1:0] paddr;
	logic [dlp_pkg::PDATA_W-1:0] pwdata;
	logic [dlp_pkg::PDATA_W-1:0] prdata;
	logic                        pready;

	dlp_char_if   char_if();
	dlp_result_if res_if();

	decimal_line_parser #(
		.LINE_CAPACITY(LINE_CAPACITY)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_in   (char_if),
		.result_out(res_if),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// Line state of the parsing model and the configured limit.
	logic [dlp_pkg::VALUE_W-1:0] max_result_cfg;
	line_phase_t                 line_phase;
	int                          line_len;
	logic [dlp_pkg::VALUE_W-1:0] line_value;
	logic                        line_overflow;

	line_result_t pending_results[$];
	logic [7:0]   line_buf[$];
	int           mismatches;
	int           words_sent;
	int           burst_left;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	function automatic void clear_line();
		line_phase    = LINE_LEAD;
		line_len      = 0;
		line_value    = '0;
		line_overflow = 1'b0;
	endfunction

	// Append one digit; values past the 31-bit range saturate and mark the line.
	function automatic void add_digit(input logic [7:0] b);
		logic [dlp_pkg::VALUE_W+3:0] wide;
		wide = {4'd0, line_value} * 10 + (b - dlp_pkg::DIGIT_LO);
		if (wide > dlp_pkg::VALUE_MAX) begin
			line_overflow = 1'b1;
			line_value    = dlp_pkg::VALUE_MAX;
		end else begin
			line_value = wide[dlp_pkg::VALUE_W-1:0];
		end
	endfunction

	// Advance the line model by one accepted word and queue any result it gives.
	function automatic void parse_word(input logic [7:0] b, input logic eof);
		line_result_t r;
		logic         is_blank;
		logic         is_digit;
		is_blank = (b <= dlp_pkg::BLANK_MAX);
		is_digit = (b >= dlp_pkg::DIGIT_LO) && (b <= dlp_pkg::DIGIT_HI);
		if (eof) begin
			r.value  = '0;
			r.status = dlp_pkg::ST_READ;
			pending_results.push_back(r);
			clear_line();
		end else if (b == dlp_pkg::NEWLINE) begin
			if ((line_phase == LINE_DIGITS || line_phase == LINE_TRAIL) && !line_overflow &&
					line_value <= max_result_cfg) begin
				r.value  = line_value;
				r.status = dlp_pkg::ST_OK;
			end else begin
				r.value  = '0;
				r.status = dlp_pkg::ST_PARSE;
			end
			pending_results.push_back(r);
			clear_line();
		end else if (line_len >= LINE_CAPACITY) begin
			line_phase = LINE_BAD;
		end else begin
			line_len++;
			case (line_phase)
				LINE_LEAD: begin
					if (is_digit) begin
						line_value = '0;
						add_digit(b);
						line_phase = LINE_DIGITS;
					end else if (!is_blank) begin
						line_phase = LINE_BAD;
					end
				end
				LINE_DIGITS: begin
					if (is_digit) begin
						add_digit(b);
					end else if (is_blank) begin
						line_phase = LINE_TRAIL;
					end else begin
						line_phase = LINE_BAD;
					end
				end
				LINE_TRAIL: begin
					if (!is_blank) begin
						line_phase = LINE_BAD;
					end
				end
				default: ;
			endcase
		end
	endfunction

	// Send one word. The sender runs in bursts separated by idle gaps.
	task automatic send_word(input logic [7:0] b, input logic eof);
		if (burst_left == 0) begin
			char_if.valid       <= 1'b0;
			char_if.char_byte   <= 8'($urandom);
			char_if.end_of_file <= 1'($urandom);
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) :
				$urandom_range(1, 16);
		end
		char_if.valid       <= 1'b1;
		char_if.char_byte   <= b;
		char_if.end_of_file <= eof;
		do @(posedge clk); while (char_if.ready !== 1'b1);
		burst_left--;
		words_sent++;
		parse_word(b, eof);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_word(s[i], 1'b0);
		end
	endtask

	task automatic stop_sending();
		char_if.valid <= 1'b0;
		burst_left = 0;
	endtask

	// Wait until every expected result has come, then let the pipeline settle.
	task automatic wait_for_results();
		int n;
		n = 0;
		while (pending_results.size() != 0 && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
		foreach (pending_results[i]) begin
			report_mismatch($sformatf("result never arrived: value %0d status %0d",
				pending_results[i].value, pending_results[i].status));
		end
		pending_results.delete();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(input logic write, input logic [dlp_pkg::PDATA_W-1:0] wdata,
			output logic [dlp_pkg::PDATA_W-1:0] rdata);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= write;
		paddr   <= MAX_RESULT_ADDR;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Reconfigure the limit only once the parser has gone idle, then read it back.
	task automatic set_max_result(input logic [dlp_pkg::PDATA_W-1:0] v);
		logic [dlp_pkg::PDATA_W-1:0] readback;
		stop_sending();
		wait_for_results();
		apb_access(1'b1, v, readback);
		max_result_cfg = v[dlp_pkg::VALUE_W-1:0];
		apb_access(1'b0, '0, readback);
		if (readback[dlp_pkg::VALUE_W-1:0] !== max_result_cfg) begin
			report_mismatch($sformatf("max_result reads %0d, expected %0d",
				readback[dlp_pkg::VALUE_W-1:0], max_result_cfg));
		end
	endtask

	function automatic logic [7:0] pick_blank();
		logic [7:0] b;
		do b = 8'($urandom_range(0, dlp_pkg::BLANK_MAX)); while (b == dlp_pkg::NEWLINE);
		return b;
	endfunction

	// One random line: mostly well-formed numbers, some with a stray byte, some
	// overlong, some plain noise and some cut short by end of file.
	task automatic send_random_line();
		int              kind;
		int              pos;
		longint unsigned value;
		logic [7:0]      stray;
		kind = $urandom_range(0, 99);
		line_buf.delete();
		if (kind < 80) begin
			repeat ($urandom_range(0, 2)) line_buf.push_back(pick_blank());
			case ($urandom_range(0, 3))
				0: value = 64'($urandom_range(0, 999));
				1: value = 64'($urandom & dlp_pkg::VALUE_MAX);
				2: value = (max_result_cfg == 0) ? 64'($urandom_range(0, 1)) :
					64'(max_result_cfg) - 64'd1 + 64'($urandom_range(0, 2));
				default: value = 64'd2147483648 + 64'($urandom % 1000000000) * 7;
			endcase
			if ($urandom_range(0, 5) == 0) begin
				repeat ($urandom_range(1, 2)) line_buf.push_back(dlp_pkg::DIGIT_LO);
			end
			pos = line_buf.size();
			do begin
				line_buf.insert(pos, 8'(dlp_pkg::DIGIT_LO + value % 10));
				value = value / 10;
			end while (value != 0);
			repeat ($urandom_range(0, 2)) line_buf.push_back(pick_blank());
			if (kind >= 70) begin
				pos = $urandom_range(0, line_buf.size() - 1);
				do stray = 8'($urandom); while (stray == dlp_pkg::NEWLINE);
				line_buf[pos] = stray;
			end
		end else if (kind < 88) begin
			repeat ($urandom_range(LINE_CAPACITY + 1, LINE_CAPACITY + 4)) begin
				line_buf.push_back(($urandom_range(0, 3) == 0) ? pick_blank() :
					8'(dlp_pkg::DIGIT_LO + $urandom_range(0, 9)));
			end
		end else if (kind < 94) begin
			repeat ($urandom_range(1, 6)) line_buf.push_back(8'($urandom));
		end else begin
			repeat ($urandom_range(0, 4)) begin
				line_buf.push_back(8'(dlp_pkg::DIGIT_LO + $urandom_range(0, 9)));
			end
		end
		foreach (line_buf[i]) begin
			send_word(line_buf[i], 1'b0);
		end
		if (kind < 88) begin
			send_word(dlp_pkg::NEWLINE, 1'b0);
		end else if (kind >= 94) begin
			send_word(8'($urandom), 1'b1);
		end
	endtask

	task automatic run_random(input int count);
		int target;
		target = words_sent + count;
		while (words_sent < target) begin
			send_random_line();
		end
	endtask

	// Value extremes, stray bytes, overlong line and end of file at reset limit.
	task automatic test_directed();
		send_text("2147483647\n");
		send_word(8'h00, 1'b0);
		send_word(dlp_pkg::NEWLINE, 1'b0);
		send_text("7 8\n");
		send_text("3");
		send_word(8'hFF, 1'b0);
		send_word(dlp_pkg::NEWLINE, 1'b0);
		send_text("12345678901\n");
		send_text("4");
		send_word(8'($urandom), 1'b1);
	endtask

	// With a zero limit only a zero value passes.
	task automatic test_max_result_zero();
		set_max_result('0);
		send_text("0\n1\n 00 \n");
		run_random(120);
	endtask

	// Random lines under a spread of limits; the top bit of the write is dropped.
	task automatic test_max_result_sweep();
		logic [dlp_pkg::PDATA_W-1:0] limits[5];
		limits = '{$urandom, $urandom_range(0, 99999), 32'h7FFF_FFFF, 32'hFFFF_FFFF,
			32'h8000_0000};
		foreach (limits[i]) begin
			set_max_result(limits[i]);
			run_random(280);
		end
	endtask

	// Result checker and consumer stall pattern.
	initial begin
		line_result_t want;
		int           stall_mode;
		int           mode_left;
		int           run_left;
		logic         ready_next;
		res_if.ready = 1'b0;
		stall_mode   = 0;
		mode_left    = 0;
		run_left     = 0;
		ready_next   = 1'b0;
		forever begin
			@(posedge clk);
			if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
				if (pending_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result: value %0d status %0d",
						res_if.parsed_value, res_if.status));
				end else begin
					want = pending_results.pop_front();
					if (res_if.parsed_value !== want.value) begin
						report_mismatch($sformatf("parsed_value %0d, expected %0d",
							res_if.parsed_value, want.value));
					end
					if (res_if.status !== want.status) begin
						report_mismatch($sformatf("status %0d, expected %0d",
							res_if.status, want.status));
					end
				end
			end
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				mode_left  = $urandom_range(64, 256);
			end
			mode_left--;
			case (stall_mode)
				0: ready_next = 1'b1;
				1: ready_next = ($urandom_range(0, 3) != 0);
				default: begin
					if (run_left == 0) begin
						ready_next = !ready_next;
						run_left   = ready_next ? $urandom_range(1, 3) : $urandom_range(1, 12);
					end
					run_left--;
				end
			endcase
			res_if.ready <= ready_next;
		end
	end

	// Watchdog on cycles in which neither channel moves a word.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((char_if.valid === 1'b1 && char_if.ready === 1'b1) ||
					(res_if.valid === 1'b1 && res_if.ready === 1'b1)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("CHECK FAILED");
		$finish;
	end

	// Test sequence.
	initial begin
		arst_n              = 1'b0;
		char_if.valid       = 1'b0;
		char_if.char_byte   = '0;
		char_if.end_of_file = 1'b0;
		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		mismatches          = 0;
		words_sent          = 0;
		burst_left          = 0;
		max_result_cfg      = dlp_pkg::VALUE_MAX;
		clear_line();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_max_result_zero();
		test_max_result_sweep();

		stop_sending();
		wait_for_results();
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
